### sv/b64d_pkg.sv
// b64d_pkg: types, constants and the character map for the base64 decoder
// no dependencies; imported by the front, queue, back, top level and test
package b64d_pkg;

	// default depth of the job queue between front and back
	localparam int unsigned QueueDepth = 4;

	// character codes of the alphabet boundaries
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperZ = 8'h5a;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerZ = 8'h7a;
	localparam logic [7:0] CharDigit0 = 8'h30;
	localparam logic [7:0] CharDigit9 = 8'h39;
	localparam logic [7:0] CharPlus   = 8'h2b;
	localparam logic [7:0] CharSlash  = 8'h2f;

	// offsets that move each character range onto its sextet values
	localparam logic [7:0] OffsLower = 8'd71;   // 'a' - 26
	localparam logic [7:0] OffsDigit = 8'd4;    // added: '0' + 4 gives 52
	localparam logic [5:0] SextetPlus  = 6'd62;
	localparam logic [5:0] SextetSlash = 6'd63;

	// one map result: invalid flag and the sextet value
	typedef struct packed {
		logic       invalid;
		logic [5:0] value;
	} sextet_t;

	// one queued job: up to three results caused by one character
	typedef struct packed {
		logic [2:0][7:0] bytes;     // byte of result i at index i
		logic [1:0]      num;       // results in this job, 1 to 3
		logic            has;       // results carry bytes
		logic            msg_end;   // the final result closes the message
		logic            stopped;   // message was halted early
	} job_t;

	// push side of the queue
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

	// map one character onto its sextet
	function automatic sextet_t sextet_of(logic [7:0] c);
		sextet_t    s;
		logic [7:0] d;
		s.invalid = 1'b0;
		s.value   = '0;
		d         = '0;
		if (c >= CharUpperA && c <= CharUpperZ) begin
			d       = c - CharUpperA;
			s.value = d[5:0];
		end else if (c >= CharLowerA && c <= CharLowerZ) begin
			d       = c - OffsLower;
			s.value = d[5:0];
		end else if (c >= CharDigit0 && c <= CharDigit9) begin
			d       = c + OffsDigit;
			s.value = d[5:0];
		end else if (c == CharPlus) begin
			s.value = SextetPlus;
		end else if (c == CharSlash) begin
			s.value = SextetSlash;
		end else begin
			s.invalid = 1'b1;
		end
		return s;
	endfunction

endpackage

### sv/b64d_in_if.sv
// b64d_in_if: character channel of the base64 decoder
// depends on nothing
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       char_last;

	modport source (output valid, output in_char, output char_last, input ready);
	modport sink   (input valid, input in_char, input char_last, output ready);
endinterface

### sv/b64d_out_if.sv
// b64d_out_if: result channel of the base64 decoder
// depends on nothing
interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       message_end;
	logic       stopped_early;

	modport source (output valid, output out_byte, output has_byte, output message_end,
		output stopped_early, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input message_end,
		input stopped_early, output ready);
endinterface

### sv/b64d_front.sv
// b64d_front: accepts characters, gathers sextets and builds result jobs
// depends on b64d_pkg and b64d_in_if
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	b64d_in_if.sink           in_ch,
	input  logic              q_full,
	output b64d_pkg::push_t   push
);
	import b64d_pkg::*;

	logic [2:0][5:0] buf_q;
	logic [1:0]      cnt_q;
	logic            halted_q;

	logic            accept;
	sextet_t         sx;
	logic            take;
	logic            full_grp;
	logic [2:0][5:0] buf_n;
	logic [1:0]      cnt_n;
	logic            halted_n;
	logic [2:0][7:0] grp_bytes;
	logic [2:0][7:0] tail_bytes;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// classify the character and work out the next group state
	always_comb begin
		sx       = sextet_of(in_ch.in_char);
		take     = !halted_q && !sx.invalid;
		full_grp = take && (cnt_q == 2'd3);
		halted_n = halted_q || sx.invalid;
		buf_n    = buf_q;
		cnt_n    = cnt_q;
		if (full_grp) begin
			cnt_n = 2'd0;
		end else if (take) begin
			buf_n[cnt_q] = sx.value;
			cnt_n        = cnt_q + 2'd1;
		end
		// complete group: three bytes from the held sextets and the new one
		grp_bytes[0] = {buf_q[0], buf_q[1][5:4]};
		grp_bytes[1] = {buf_q[1][3:0], buf_q[2][5:2]};
		grp_bytes[2] = {buf_q[2][1:0], sx.value};
		// partial group flushed at the end of a message
		tail_bytes[0] = {buf_n[0], buf_n[1][5:4]};
		tail_bytes[1] = {buf_n[1][3:0], buf_n[2][5:2]};
		tail_bytes[2] = '0;
	end

	// job for the queue
	always_comb begin
		push.valid       = accept && (full_grp || in_ch.char_last);
		push.job.msg_end = in_ch.char_last;
		push.job.stopped = in_ch.char_last && halted_n;
		if (full_grp) begin
			push.job.bytes = grp_bytes;
			push.job.num   = 2'd3;
			push.job.has   = 1'b1;
		end else if (cnt_n >= 2'd2) begin
			push.job.bytes = tail_bytes;
			push.job.num   = cnt_n - 2'd1;
			push.job.has   = 1'b1;
		end else begin
			push.job.bytes = '0;
			push.job.num   = 2'd1;
			push.job.has   = 1'b0;
		end
	end

	// group state, cleared at the end of each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			cnt_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (in_ch.char_last) begin
				buf_q    <= '0;
				cnt_q    <= '0;
				halted_q <= 1'b0;
			end else begin
				buf_q    <= buf_n;
				cnt_q    <= cnt_n;
				halted_q <= halted_n;
			end
		end
	end

	// halted message holds its group, a full group always clears the count
	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halted_q && !in_ch.char_last |=> $stable(cnt_q) && halted_q)
		else $error("halted message changed group state");
	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full_grp && !in_ch.char_last |=> cnt_q == 2'd0)
		else $error("complete group did not clear the count");
	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !q_full)
		else $error("job pushed into a full queue");

endmodule

### sv/b64d_queue.sv
// b64d_queue: short job queue that decouples the front end from the back end
// depends on b64d_pkg
module b64d_queue #(
	parameter int unsigned DEPTH = b64d_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  b64d_pkg::push_t push,
	output logic            full,
	output b64d_pkg::head_t head,
	input  logic            pop
);
	import b64d_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = mem_q[rd_ptr_q];

	// job storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from an empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost in queue count");

endmodule

### sv/b64d_back.sv
// b64d_back: emits the results of each queued job, one transfer per cycle while the receiver is ready
// depends on b64d_pkg and b64d_out_if
module b64d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b64d_pkg::head_t head,
	output logic            pop,
	b64d_out_if.source      out_ch
);
	import b64d_pkg::*;

	logic [1:0] sub_q;
	logic       last_sub;
	logic       xfer;

	assign last_sub = (sub_q == head.job.num - 2'd1);
	assign xfer     = out_ch.valid && out_ch.ready;
	assign pop      = xfer && last_sub;

	// result fields of the current job entry
	always_comb begin
		out_ch.valid         = head.valid;
		out_ch.has_byte      = head.job.has;
		out_ch.out_byte      = head.job.has ? head.job.bytes[sub_q] : '0;
		out_ch.message_end   = head.job.msg_end && last_sub;
		out_ch.stopped_early = head.job.stopped && last_sub;
	end

	// position within the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
		end else if (xfer) begin
			sub_q <= last_sub ? 2'd0 : sub_q + 2'd1;
		end
	end

	a_sub_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.job.num != 2'd0) && (sub_q < head.job.num))
		else $error("result index outside its job");
	a_idle_sub: assert property (@(posedge clk) disable iff (!arst_n)
		!head.valid |-> sub_q == 2'd0)
		else $error("result index left over with an empty queue");
	a_stop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stopped_early |-> out_ch.message_end)
		else $error("early stop flagged off the end result");

endmodule

### sv/base64_decoder.sv
// base64_decoder: streaming base64 decoder, top level
// depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue, b64d_back
//
// Takes one character per transfer and gives decoded bytes one per transfer. The front
// end accepts a character every cycle while the job queue has room; characters that
// complete a group of four, or end a message, push one job of one to three results.
// The back end drains a job at one result per cycle while the receiver is ready, so
// the front end keeps accepting while a complete group goes out. Four characters give
// at most three results, so one character per cycle is sustained while the receiver
// is ready; the queue depth (QUEUE_DEPTH jobs) sets how long the output may stall
// before input is held off. Every result is registered in the job queue first.
module base64_decoder #(
	parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	b64d_in_if.sink    in_ch,
	b64d_out_if.source out_ch
);
	import b64d_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

### test/base64_decoder_test.sv
// base64_decoder_test: self-checking bench for the streaming base64 decoder
// drives characters through b64d_in_if, checks bytes from b64d_out_if against a decode predictor
// depends on b64d_pkg, b64d_in_if, b64d_out_if and base64_decoder
module base64_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	// one decoded result as seen on the output channel
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       message_end;
		logic       stopped_early;
	} dec_res_t;

	// one row of the directed table; typed rows carry their own expected results
	typedef struct packed {
		logic [7:0]       c;
		logic             last;
		logic             typed;
		logic [1:0]       n;
		dec_res_t [0:2]   res;
	} stim_row_t;

	localparam logic [7:0] PadChar     = 8'h3d;
	localparam int         StallLimit  = 3000;
	localparam int         HoldCycles  = 120;
	localparam int         DrainCycles = 16;
	localparam int         DirRows     = 25;
	localparam logic [8*64-1:0] B64Alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// results whose value is plain from the alphabet extremes
	localparam dec_res_t NoRes      = '0;
	localparam dec_res_t EmptyEnd   = '{8'h00, 1'b0, 1'b1, 1'b0};
	localparam dec_res_t HaltedEnd  = '{8'h00, 1'b0, 1'b1, 1'b1};
	localparam dec_res_t ByteFF     = '{8'hff, 1'b1, 1'b0, 1'b0};
	localparam dec_res_t ByteFFEnd  = '{8'hff, 1'b1, 1'b1, 1'b0};
	localparam dec_res_t Byte00     = '{8'h00, 1'b1, 1'b0, 1'b0};
	localparam dec_res_t Byte00End  = '{8'h00, 1'b1, 1'b1, 1'b0};

	// directed stimulus: extremes, every alphabet range, partial groups, halting
	localparam stim_row_t DirTable [DirRows] = '{
		'{PadChar,    1'b1, 1'b1, 2'd1, '{HaltedEnd, NoRes, NoRes}},   // '=' right after reset
		'{CharUpperA, 1'b1, 1'b1, 2'd1, '{EmptyEnd, NoRes, NoRes}},    // single sextet, no byte
		'{CharSlash,  1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharSlash,  1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharSlash,  1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharSlash,  1'b1, 1'b1, 2'd3, '{ByteFF, ByteFF, ByteFFEnd}}, // all ones group
		'{CharUpperA, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharUpperA, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharUpperA, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharUpperA, 1'b1, 1'b1, 2'd3, '{Byte00, Byte00, Byte00End}}, // all zeros group
		'{CharUpperZ, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharLowerZ, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharDigit0, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharDigit9, 1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharPlus,   1'b1, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{"T",        1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},       // two sextets, one byte
		'{"Q",        1'b1, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{"T",        1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},       // three sextets, two bytes
		'{"W",        1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{"E",        1'b1, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{"T",        1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},       // high character halts
		'{"W",        1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{8'h80,      1'b0, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{CharUpperA, 1'b1, 1'b0, 2'd0, '{NoRes, NoRes, NoRes}},
		'{8'hff,      1'b1, 1'b1, 2'd1, '{HaltedEnd, NoRes, NoRes}}
	};

	logic clk = 1'b0;
	logic arst_n;

	b64d_in_if  char_ch ();
	b64d_out_if byte_ch ();

	base64_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (char_ch),
		.out_ch (byte_ch)
	);

	// decode predictor state
	logic [5:0] dec_sextets [3];
	logic [1:0] dec_count;
	logic       dec_halted;

	dec_res_t decoded_q [$];
	int       decode_items;
	int       mismatch_count;
	int       src_idle_pct;
	int       sink_idle_pct;
	logic     hold_active;
	event     hold_start;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// map one character onto {invalid, sextet}
	function automatic logic [6:0] sextet_of_char(input logic [7:0] c);
		logic [7:0] d;
		d = '0;
		if (c >= CharUpperA && c <= CharUpperZ) begin
			d = c - CharUpperA;
		end else if (c >= CharLowerA && c <= CharLowerZ) begin
			d = c - CharLowerA + 8'd26;
		end else if (c >= CharDigit0 && c <= CharDigit9) begin
			d = c - CharDigit0 + 8'd52;
		end else if (c == CharPlus) begin
			d = {2'b00, SextetPlus};
		end else if (c == CharSlash) begin
			d = {2'b00, SextetSlash};
		end else begin
			return 7'h40;
		end
		return {1'b0, d[5:0]};
	endfunction

	// advance the decode state by one character and give the bytes it releases
	function automatic int predict_decode(input logic [7:0] c, input logic last,
		output dec_res_t [0:2] res);
		logic [6:0] sx;
		logic [5:0] s0, s1, s2;
		int         n;
		n   = 0;
		res = '0;
		s0  = dec_sextets[0];
		s1  = dec_sextets[1];
		s2  = dec_sextets[2];
		if (!dec_halted) begin
			sx = sextet_of_char(c);
			if (sx[6]) begin
				dec_halted = 1'b1;
			end else if (dec_count == 2'd3) begin
				// fourth sextet completes the group
				res[0]    = '{{s0, s1[5:4]}, 1'b1, 1'b0, 1'b0};
				res[1]    = '{{s1[3:0], s2[5:2]}, 1'b1, 1'b0, 1'b0};
				res[2]    = '{{s2[1:0], sx[5:0]}, 1'b1, 1'b0, 1'b0};
				n         = 3;
				dec_count = 2'd0;
			end else begin
				dec_sextets[dec_count] = sx[5:0];
				dec_count              = dec_count + 2'd1;
			end
		end
		if (last) begin
			// flush a partial group, then mark the end of the message
			s0 = dec_sextets[0];
			s1 = dec_sextets[1];
			s2 = dec_sextets[2];
			if (dec_count >= 2'd2) begin
				res[n] = '{{s0, s1[5:4]}, 1'b1, 1'b0, 1'b0};
				n      = n + 1;
			end
			if (dec_count == 2'd3) begin
				res[n] = '{{s1[3:0], s2[5:2]}, 1'b1, 1'b0, 1'b0};
				n      = n + 1;
			end
			if (n == 0) begin
				res[0] = '0;
				n      = 1;
			end
			res[n-1].message_end   = 1'b1;
			res[n-1].stopped_early = dec_halted;
			dec_sextets = '{default: '0};
			dec_count   = 2'd0;
			dec_halted  = 1'b0;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("mismatch at %0t: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// offer one character, wait for its transfer, then record what it should give
	task automatic transfer_char(input logic [7:0] c, input logic last, input logic typed,
		input int n_typed, input dec_res_t [0:2] typed_res);
		dec_res_t [0:2] pred;
		int             n;
		int             i;
		while ($urandom_range(99) < src_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid     <= 1'b1;
		char_ch.in_char   <= c;
		char_ch.char_last <= last;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		decode_items++;
		n = predict_decode(c, last, pred);
		if (typed) begin
			pred = typed_res;
			n    = n_typed;
		end
		for (i = 0; i < n; i++)
			decoded_q = {decoded_q, pred[i]};
	endtask

	// sender stops offering until every expected byte has come out
	task automatic wait_drained();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	// one random message: mostly clean text, some padded, some with bad characters
	task automatic send_message();
		int         len;
		int         kind;
		int         bad_pos;
		int         pad_n;
		int         i;
		logic [7:0] c;
		len     = $urandom_range(1, 14);
		kind    = $urandom_range(99);
		bad_pos = $urandom_range(0, len - 1);
		pad_n   = $urandom_range(1, 2);
		for (i = 0; i < len; i++) begin
			c = B64Alphabet[8 * (63 - $urandom_range(63)) +: 8];
			if (kind >= 95)
				c = 8'($urandom_range(255));
			else if (kind >= 85 && i == bad_pos)
				c = 8'($urandom_range(255));
			else if (kind >= 70 && i >= 1 && i >= len - pad_n)
				c = PadChar;
			transfer_char(c, i == len - 1, 1'b0, 0, '0);
		end
	endtask

	// receiver: random stalls, or a long hold-off when one is running
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_ch.ready <= 1'b0;
		else
			byte_ch.ready <= !hold_active && ($urandom_range(99) >= sink_idle_pct);
	end

	// long hold-off, counted on the falling edge so the receiver sees a settled flag
	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_start);
			@(negedge clk);
			hold_active = 1'b1;
			repeat (HoldCycles) @(negedge clk);
			hold_active = 1'b0;
		end
	end

	// compare each output transfer with the oldest expected result
	always @(posedge clk) begin
		dec_res_t got;
		dec_res_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			got = '{byte_ch.out_byte, byte_ch.has_byte, byte_ch.message_end,
				byte_ch.stopped_early};
			if (decoded_q.size() == 0) begin
				report_mismatch("result with nothing pending", int'(got), 0);
			end else begin
				want = decoded_q.pop_front();
				if (got.data !== want.data)
					report_mismatch("out_byte", int'(got.data), int'(want.data));
				if (got.has_byte !== want.has_byte)
					report_mismatch("has_byte", int'(got.has_byte), int'(want.has_byte));
				if (got.message_end !== want.message_end)
					report_mismatch("message_end", int'(got.message_end),
						int'(want.message_end));
				if (got.stopped_early !== want.stopped_early)
					report_mismatch("stopped_early", int'(got.stopped_early),
						int'(want.stopped_early));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		int quiet_cycles;
		if ((char_ch.valid && char_ch.ready) || (byte_ch.valid && byte_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin
		int r;
		arst_n            <= 1'b0;
		char_ch.valid     <= 1'b0;
		char_ch.in_char   <= '0;
		char_ch.char_last <= 1'b0;
		dec_sextets    = '{default: '0};
		dec_count      = 2'd0;
		dec_halted     = 1'b0;
		decode_items   = 0;
		mismatch_count = 0;
		src_idle_pct   = 32;
		sink_idle_pct  = 82;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (r = 0; r < DirRows; r++)
			transfer_char(DirTable[r].c, DirTable[r].last, DirTable[r].typed,
				int'(DirTable[r].n), DirTable[r].res);
		wait_drained();

		// random messages, slow sender and slower receiver
		while (decode_items < 90)
			send_message();
		wait_drained();

		// roles swapped
		src_idle_pct  = 82;
		sink_idle_pct = 32;
		while (decode_items < 180)
			send_message();
		wait_drained();

		// no idling; the receiver holds off while characters keep coming
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		-> hold_start;
		while (decode_items < 260)
			send_message();

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### base64_decoder.f
sv/b64d_pkg.sv
sv/b64d_in_if.sv
sv/b64d_out_if.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_decoder.sv
test/base64_decoder_test.sv
